// ===== rtl/battery_voltage_fuel_gauge_defines.svh =====
// assertion macros shared by the fuel gauge rtl
`ifndef BATTERY_VOLTAGE_FUEL_GAUGE_DEFINES_SVH
`define BATTERY_VOLTAGE_FUEL_GAUGE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BVFG_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BVFG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bvfg_pkg.sv =====
// shared constants, codes and control types of the fuel gauge
package bvfg_pkg;

  localparam int MV_W        = 16;
  localparam int TOTAL_W     = 32;
  localparam int SOC_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DIV_W       = 32;
  localparam int DVS_W       = 16;
  localparam int DIV_CNT_W   = 5;
  localparam int AVG_DEPTH_DEF = 8;

  localparam logic [SOC_W-1:0] SOC_MAX = 7'd100;
  localparam logic [SOC_W-1:0] SOC_MIN = 7'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOC_FULL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOC_EMPTY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_RANGE = 2'd2;

  // divider operand select
  localparam logic [1:0] DIV_CYC = 2'd0;
  localparam logic [1:0] DIV_SOC = 2'd2;

  typedef struct packed {
    logic       load;
    logic       fill;
    logic       ring_rd;
    logic       ring_upd;
    logic       div_go;
    logic [1:0] div_sel;
    logic       cyc_cap;
    logic       avg_cap;
    logic       soc_clamp;
    logic       soc_cap;
    logic       charge_step;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic above_empty;
    logic soc_mid;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/bvfg_ifs.sv =====
// valid/ready channel interfaces for sample input and gauge result
interface bvfg_in_if;
  import bvfg_pkg::*;
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] sample_mv;
  logic            charging;

  modport source (output valid, sample_mv, charging, input ready);
  modport sink   (input valid, sample_mv, charging, output ready);
endinterface

interface bvfg_out_if;
  import bvfg_pkg::*;
  logic               valid;
  logic               ready;
  logic [SOC_W-1:0]   soc_percent;
  logic [MV_W-1:0]    filtered_mv;
  logic [MV_W-1:0]    charge_start_mv;
  logic [MV_W-1:0]    recovered_mv;
  logic [TOTAL_W-1:0] total_recovered_mv;
  logic [MV_W-1:0]    cycle_count;
  logic               charge_state;

  modport source (output valid, soc_percent, filtered_mv, charge_start_mv, recovered_mv,
                  total_recovered_mv, cycle_count, charge_state, input ready);
  modport sink   (input valid, soc_percent, filtered_mv, charge_start_mv, recovered_mv,
                  total_recovered_mv, cycle_count, charge_state, output ready);
endinterface

// ===== rtl/battery_voltage_fuel_gauge.sv =====
// top level of the voltage based battery fuel gauge with moving average filter
// per transaction: ring read and update, cycle count division, average, soc division
// (none when soc is clamped), charge step, result; one shared 32-step restoring divider
// one transaction in flight; a transaction before start gives no result
// reset (rst_n low, synchronous): config back to 4200/3000/1200 mv, gauge state cleared
// the averaging ring needs no clearing pass; it is only read after the first fill
module battery_voltage_fuel_gauge #(
  parameter int AVG_DEPTH = bvfg_pkg::AVG_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bvfg_in_if.sink                         in_ch,
  bvfg_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bvfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bvfg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bvfg_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t st;

  // sequencer: accepts a transaction only when idle, holds the result
  // in the output register until the sink takes it, and keeps accepting
  // new input while that result waits
  bvfg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: config registers, ring memory with running sum, divider,
  // charge/discharge tracking and the result register
  bvfg_dp #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .st                     (st),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_sample_mv           (in_ch.sample_mv),
    .in_charging            (in_ch.charging),
    .out_soc_percent        (out_ch.soc_percent),
    .out_filtered_mv        (out_ch.filtered_mv),
    .out_charge_start_mv    (out_ch.charge_start_mv),
    .out_recovered_mv       (out_ch.recovered_mv),
    .out_total_recovered_mv (out_ch.total_recovered_mv),
    .out_cycle_count        (out_ch.cycle_count),
    .out_charge_state       (out_ch.charge_state)
  );

endmodule

// ===== rtl/bvfg_div.sv =====
// restoring divider, one quotient bit per cycle
module bvfg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [bvfg_pkg::DIV_W-1:0] dividend,
  input  logic [bvfg_pkg::DVS_W-1:0] divisor,
  output logic [bvfg_pkg::DIV_W-1:0] quot,
  output logic                       done,
  output logic                       busy
);
  import bvfg_pkg::*;

  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DVS_W:0]       shifted;
  logic                 ge;

  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DVS_W'(shifted - {1'b0, dvs_r}) : shifted[DVS_W-1:0];
      q_nxt   = {q_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot = q_r;
  assign done = done_r;
  assign busy = busy_r;

endmodule

// ===== rtl/bvfg_dp.sv =====
// datapath: config registers, averaging ring, divider operands, charge tracking
`include "battery_voltage_fuel_gauge_defines.svh"

module bvfg_dp #(
  parameter int AVG_DEPTH = bvfg_pkg::AVG_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bvfg_pkg::dp_cmd_t               cmd,
  output bvfg_pkg::dp_stat_t              st,
  input  logic                            cfg_we,
  input  logic [bvfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bvfg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [bvfg_pkg::MV_W-1:0]       in_sample_mv,
  input  logic                            in_charging,
  output logic [bvfg_pkg::SOC_W-1:0]      out_soc_percent,
  output logic [bvfg_pkg::MV_W-1:0]       out_filtered_mv,
  output logic [bvfg_pkg::MV_W-1:0]       out_charge_start_mv,
  output logic [bvfg_pkg::MV_W-1:0]       out_recovered_mv,
  output logic [bvfg_pkg::TOTAL_W-1:0]    out_total_recovered_mv,
  output logic [bvfg_pkg::MV_W-1:0]       out_cycle_count,
  output logic                            out_charge_state
);
  import bvfg_pkg::*;

  localparam int PTR_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W = MV_W + CNT_W;

  // average by reciprocal multiply, exact for every sum the ring can hold
  localparam int AVG_SH    = SUM_W + $clog2(AVG_DEPTH);
  localparam int AVG_MUL_W = SUM_W + 1;
  localparam int AVG_PRD_W = SUM_W + AVG_MUL_W;
  localparam longint unsigned AVG_MUL = ((64'd1 << AVG_SH) + AVG_DEPTH - 1) / AVG_DEPTH;

  // config
  logic [MV_W-1:0] full_r, empty_r, range_r;

  // per-transaction input and intermediate results
  logic [MV_W-1:0]  sample_r;
  logic             chg_r;
  logic [MV_W-1:0]  cyc_r;
  logic [SOC_W-1:0] soc_r;

  // ring bookkeeping: entries older than the last fill read as fill_val_r
  logic [MV_W-1:0]  ring_mem [AVG_DEPTH];
  logic [MV_W-1:0]  ring_rd_r;
  logic [MV_W-1:0]  fill_val_r, fill_val_nxt;
  logic [PTR_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [MV_W-1:0]  old_val;
  logic [AVG_PRD_W-1:0] avg_prod;

  // gauge state
  logic                act_r, act_nxt;
  logic [MV_W-1:0]     avg_r, avg_nxt;
  logic [MV_W-1:0]     start_r, start_nxt;
  logic [MV_W-1:0]     cycle_r, cycle_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;

  logic                chg_begin, chg_end, refill;
  logic [MV_W-1:0]     avg_fin;
  logic [MV_W-1:0]     soc_span, soc_off;
  logic [DIV_W-1:0]    div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  logic [DIV_W-1:0]    div_quot;
  logic                div_done, div_busy;

  // output register
  logic [SOC_W-1:0]   o_soc_r;
  logic [MV_W-1:0]    o_filt_r, o_start_r, o_rec_r, o_cyc_r;
  logic [TOTAL_W-1:0] o_total_r;
  logic               o_chg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r  <= MV_W'(4200);
      empty_r <= MV_W'(3000);
      range_r <= MV_W'(1200);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOC_FULL:    full_r  <= cfg_data;
        REG_SOC_EMPTY:   empty_r <= cfg_data;
        REG_CYCLE_RANGE: range_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign old_val  = (cnt_r == CNT_W'(AVG_DEPTH)) ? ring_rd_r : fill_val_r;
  assign soc_span = full_r - empty_r;
  assign soc_off  = avg_r - empty_r;
  assign avg_prod = AVG_PRD_W'(sum_r) * AVG_PRD_W'(AVG_MUL);

  always_comb begin
    case (cmd.div_sel)
      DIV_SOC: begin
        div_dividend = DIV_W'(soc_off) * DIV_W'(SOC_MAX);
        div_divisor  = soc_span;
      end
      default: begin
        div_dividend = total_r;
        div_divisor  = range_r;
      end
    endcase
  end

  bvfg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .done     (div_done),
    .busy     (div_busy)
  );

  // charge state machine
  assign chg_begin = !act_r && chg_r;
  assign chg_end   = act_r && !chg_r;
  assign refill    = chg_begin || chg_end;
  assign avg_fin   = refill ? sample_r : avg_r;

  always_comb begin
    act_nxt      = act_r;
    avg_nxt      = avg_r;
    start_nxt    = start_r;
    cycle_nxt    = cycle_r;
    total_nxt    = total_r;
    sum_nxt      = sum_r;
    fill_val_nxt = fill_val_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    if (cmd.fill) begin
      avg_nxt      = sample_r;
      sum_nxt      = SUM_W'(sample_r) * SUM_W'(AVG_DEPTH);
      fill_val_nxt = sample_r;
      cnt_nxt      = '0;
    end
    if (cmd.ring_upd) begin
      sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(sample_r);
      pos_nxt = (pos_r == PTR_W'(AVG_DEPTH - 1)) ? '0 : pos_r + 1'b1;
      if (cnt_r != CNT_W'(AVG_DEPTH)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (cmd.avg_cap) begin
      avg_nxt = avg_prod[AVG_SH +: MV_W];
    end
    if (cmd.charge_step) begin
      act_nxt   = chg_r;
      avg_nxt   = avg_fin;
      start_nxt = chg_begin ? avg_r : start_r;
      if (chg_end) begin
        total_nxt = total_r + TOTAL_W'(cycle_r);
      end
      if (refill) begin
        sum_nxt      = SUM_W'(sample_r) * SUM_W'(AVG_DEPTH);
        fill_val_nxt = sample_r;
        cnt_nxt      = '0;
      end
      if (chg_r) begin
        cycle_nxt = (avg_fin > start_nxt) ? avg_fin - start_nxt : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ring_upd) begin
      ring_mem[pos_r] <= sample_r;
    end
    if (cmd.ring_rd) begin
      ring_rd_r <= ring_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample_mv;
      chg_r    <= in_charging;
    end
    if (cmd.cyc_cap) begin
      cyc_r <= (|div_quot[DIV_W-1:MV_W]) ? {MV_W{1'b1}} : div_quot[MV_W-1:0];
    end
    if (cmd.soc_clamp) begin
      soc_r <= (avg_r <= empty_r) ? SOC_MIN : SOC_MAX;
    end else if (cmd.soc_cap) begin
      soc_r <= div_quot[SOC_W-1:0];
    end
    if (cmd.out_load) begin
      o_soc_r   <= soc_r;
      o_filt_r  <= avg_r;
      o_start_r <= start_r;
      o_rec_r   <= cycle_r;
      o_total_r <= total_r;
      o_cyc_r   <= cyc_r;
      o_chg_r   <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r      <= 1'b0;
      avg_r      <= '0;
      start_r    <= '0;
      cycle_r    <= '0;
      total_r    <= '0;
      sum_r      <= '0;
      fill_val_r <= '0;
      cnt_r      <= '0;
      pos_r      <= '0;
    end else begin
      act_r      <= act_nxt;
      avg_r      <= avg_nxt;
      start_r    <= start_nxt;
      cycle_r    <= cycle_nxt;
      total_r    <= total_nxt;
      sum_r      <= sum_nxt;
      fill_val_r <= fill_val_nxt;
      cnt_r      <= cnt_nxt;
      pos_r      <= pos_nxt;
    end
  end

  assign st.above_empty = sample_r >= empty_r;
  assign st.soc_mid     = (avg_r > empty_r) && (avg_r < full_r);
  assign st.div_done    = div_done;

  assign out_soc_percent        = o_soc_r;
  assign out_filtered_mv        = o_filt_r;
  assign out_charge_start_mv    = o_start_r;
  assign out_recovered_mv       = o_rec_r;
  assign out_total_recovered_mv = o_total_r;
  assign out_cycle_count        = o_cyc_r;
  assign out_charge_state       = o_chg_r;

  `BVFG_ASSERT_IMP(a_div_go_idle, cmd.div_go, !div_busy, "divider started while busy")
  `BVFG_ASSERT_IMP(a_fill_cnt_range, 1'b1, cnt_r <= CNT_W'(AVG_DEPTH), "fill count overrun")
  `BVFG_ASSERT_NXT(a_soc_range, cmd.out_load, o_soc_r <= SOC_MAX, "soc above full scale")

endmodule

// ===== rtl/bvfg_ctrl.sv =====
// controller: sequences ring update, divisions and charge step per transaction once started
`include "battery_voltage_fuel_gauge_defines.svh"

module bvfg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bvfg_pkg::dp_stat_t  st,
  output bvfg_pkg::dp_cmd_t   cmd
);
  import bvfg_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_UPD   = 4'd2;
  localparam logic [3:0] S_DCYC  = 4'd3;
  localparam logic [3:0] S_AVG   = 4'd4;
  localparam logic [3:0] S_SOC   = 4'd6;
  localparam logic [3:0] S_DSOC  = 4'd7;
  localparam logic [3:0] S_STEP  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       started_r, started_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    cmd         = '0;
    cmd.div_sel = DIV_CYC;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!started_r) begin
          if (st.above_empty) begin
            cmd.fill    = 1'b1;
            started_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end else begin
          cmd.ring_rd = 1'b1;
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_CYC;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        cmd.ring_upd = 1'b1;
        state_nxt    = S_DCYC;
      end
      S_DCYC: begin
        if (st.div_done) begin
          cmd.cyc_cap = 1'b1;
          state_nxt   = S_AVG;
        end
      end
      S_AVG: begin
        cmd.avg_cap = 1'b1;
        state_nxt   = S_SOC;
      end
      S_SOC: begin
        if (st.soc_mid) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_SOC;
          state_nxt   = S_DSOC;
        end else begin
          cmd.soc_clamp = 1'b1;
          state_nxt     = S_STEP;
        end
      end
      S_DSOC: begin
        if (st.div_done) begin
          cmd.soc_cap = 1'b1;
          state_nxt   = S_STEP;
        end
      end
      S_STEP: begin
        cmd.charge_step = 1'b1;
        state_nxt       = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `BVFG_ASSERT_IMP(a_out_slot_free, cmd.out_load, !out_valid_r || out_ready, "result overwritten")
  `BVFG_ASSERT_NXT(a_started_sticky, started_r, started_r, "started flag dropped")
  `BVFG_ASSERT_IMP(a_done_when_waiting, st.div_done,
    state_r == S_DCYC || state_r == S_DSOC, "divider done out of sequence")

endmodule
